[hdl/pid_with_windup_clamp_macros.svh]
// Assertion helpers for the PID block.
`ifndef PID_WITH_WINDUP_CLAMP_MACROS_SVH
`define PID_WITH_WINDUP_CLAMP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PWC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define PWC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PWC_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define PWC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

[hdl/pid_wc_pkg.sv]
package pid_wc_pkg;

    localparam int ERROR_WIDTH = 16;
    localparam int ACCUM_WIDTH = 32;

    localparam int GAIN_W   = 16;
    localparam int TS_W     = 16;
    localparam int LIMIT_W  = 31;
    localparam int DRIVE_W  = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LIMIT_W;

    localparam int IN_TDATA_W  = ((ERROR_WIDTH + TS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DRIVE_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    // shared multiplier: small unsigned operand (gain or step) times a wide signed one
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = (ACCUM_WIDTH > ERROR_WIDTH) ? ACCUM_WIDTH : ERROR_WIDTH;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // integrator update and clamp width
    localparam int SUM_W0 = (ACCUM_WIDTH > PROD_W - 16) ? ACCUM_WIDTH : PROD_W - 16;
    localparam int SUM_W  = ((SUM_W0 > LIMIT_W) ? SUM_W0 : LIMIT_W) + 1;

    // three gain terms summed
    localparam int TOT_W = PROD_W - 8 + 2;

    // derivative divider, two quotient bits per cycle
    localparam int DIV_N     = ERROR_WIDTH + 1 + TS_W;
    localparam int DIV_STEPS = (DIV_N + 1) / 2;
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int DSAT_W    = ((DIV_W > ACCUM_WIDTH) ? DIV_W : ACCUM_WIDTH) + 1;

    localparam logic [ACCUM_WIDTH-1:0] ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_P_GAIN = 2'd0;
    localparam cfg_idx_t CFG_I_GAIN = 2'd1;
    localparam cfg_idx_t CFG_D_GAIN = 2'd2;
    localparam cfg_idx_t CFG_LIMIT  = 2'd3;

    typedef logic [GAIN_W-1:0] gain_t;

endpackage

[hdl/pid_with_windup_clamp.sv]
// PID controller with anti-windup clamp.
//
// s_ channel: one item per control sample, error (signed Q3.12) and time
// step (unsigned Q0.16 s). m_ channel: one item per sample, the saturated
// drive value (Q.12) in tdata, clamp and zero-step flags in tuser.
// Gains and the windup limit are written through cfg_wr_en/cfg_index/
// cfg_wdata while the block is idle; they take effect on the next item.
//
// An item is taken only while s_tready is high. It then runs through a
// small sequencer: step product, integrator clamp, a radix-4 restoring
// divider for the derivative with quotient saturation, then three gain
// products on the one shared multiplier and the saturated final sum. The
// result register is loaded in the same cycle that s_tready returns, so a
// new item is taken only once the previous one has left the sequencer.
// If m_tready is low the finished item waits in the output register; a
// new item is still accepted, and the next result waits for the register.
// Reset (aresetn low, synchronous) restores default gains and limit, clears
// the integrator and previous error and drops m_tvalid.
`include "pid_with_windup_clamp_macros.svh"

module pid_with_windup_clamp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pid_wc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pid_wc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // error_sample, time_step
    input  logic [pid_wc_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // drive_value
    output logic [pid_wc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // integrator_clamped, zero_step
    output logic [pid_wc_pkg::OUT_TUSER_W-1:0]   m_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_EDT,
        ST_CLAMP,
        ST_DIV,
        ST_DSAT,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SUM
    } state_t;

    state_t state_reg, state_next;

    pid_wc_pkg::gain_t                        p_gain_reg, i_gain_reg, d_gain_reg;
    logic [pid_wc_pkg::LIMIT_W-1:0]           limit_reg;

    logic signed [pid_wc_pkg::ERROR_WIDTH-1:0] e_reg, prev_reg;
    logic [pid_wc_pkg::TS_W-1:0]               dt_reg;
    logic signed [pid_wc_pkg::ACCUM_WIDTH-1:0] integ_reg, deriv_reg;
    logic                                      dneg_reg, clamped_reg;

    logic [pid_wc_pkg::DIV_W-1:0]     div_reg, div_next;
    logic [pid_wc_pkg::TS_W-1:0]      rem_reg, rem_next;
    logic [pid_wc_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic signed [pid_wc_pkg::PROD_W-1:0] prod_reg;
    logic signed [pid_wc_pkg::TOT_W-1:0]  acc_reg;

    logic                                  m_valid_reg;
    logic [pid_wc_pkg::DRIVE_W-1:0]        m_drive_reg;
    logic                                  m_clamp_reg, m_zero_reg;

    logic in_acc, out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // input unpack and derivative numerator
    logic signed [pid_wc_pkg::ERROR_WIDTH-1:0] e_in;
    logic [pid_wc_pkg::TS_W-1:0]               dt_in;
    logic signed [pid_wc_pkg::ERROR_WIDTH:0]   diff;
    logic [pid_wc_pkg::ERROR_WIDTH:0]          mag;

    assign e_in  = s_tdata[pid_wc_pkg::ERROR_WIDTH-1:0];
    assign dt_in = s_tdata[pid_wc_pkg::ERROR_WIDTH +: pid_wc_pkg::TS_W];
    assign diff  = (pid_wc_pkg::ERROR_WIDTH + 1)'(e_in)
                 - (pid_wc_pkg::ERROR_WIDTH + 1)'(prev_reg);
    assign mag   = diff[pid_wc_pkg::ERROR_WIDTH] ? $unsigned(-diff) : $unsigned(diff);

    // shared multiplier
    logic signed [pid_wc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pid_wc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [pid_wc_pkg::PROD_W-1:0]  prod;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_EDT: begin
                mul_a = $signed({1'b0, dt_reg});
                mul_b = pid_wc_pkg::MUL_B_W'(e_reg);
            end
            ST_MUL_P: begin
                mul_a = $signed({1'b0, p_gain_reg});
                mul_b = pid_wc_pkg::MUL_B_W'(e_reg);
            end
            ST_MUL_I: begin
                mul_a = $signed({1'b0, i_gain_reg});
                mul_b = pid_wc_pkg::MUL_B_W'(integ_reg);
            end
            ST_MUL_D: begin
                mul_a = $signed({1'b0, d_gain_reg});
                mul_b = pid_wc_pkg::MUL_B_W'(deriv_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // integrator update against the effective bound
    logic [pid_wc_pkg::SUM_W-1:0]        lim_u, amax_u, bound_u;
    logic signed [pid_wc_pkg::SUM_W-1:0] bound_s, sum, sum_clamped, integ_ext;
    logic                                clamp_hit;

    assign lim_u   = pid_wc_pkg::SUM_W'(limit_reg);
    assign amax_u  = pid_wc_pkg::SUM_W'(pid_wc_pkg::ACC_MAX);
    assign bound_u = (amax_u < lim_u) ? amax_u : lim_u;
    assign bound_s = $signed(bound_u);
    assign sum     = pid_wc_pkg::SUM_W'(integ_reg) + pid_wc_pkg::SUM_W'(prod_reg >>> 16);
    assign integ_ext = pid_wc_pkg::SUM_W'(integ_reg);

    always_comb begin
        sum_clamped = sum;
        clamp_hit   = 1'b0;
        if (sum < -bound_s) begin
            sum_clamped = -bound_s;
            clamp_hit   = 1'b1;
        end else if (sum > bound_s) begin
            sum_clamped = bound_s;
            clamp_hit   = 1'b1;
        end
    end

    // two restoring division steps per cycle
    logic [pid_wc_pkg::TS_W:0] r1, r2;
    logic                      q1, q2;

    always_comb begin
        r1 = {rem_reg, div_reg[pid_wc_pkg::DIV_W-1]};
        q1 = (r1 >= {1'b0, dt_reg});
        if (q1) begin
            r1 = r1 - {1'b0, dt_reg};
        end
        r2 = {r1[pid_wc_pkg::TS_W-1:0], div_reg[pid_wc_pkg::DIV_W-2]};
        q2 = (r2 >= {1'b0, dt_reg});
        if (q2) begin
            r2 = r2 - {1'b0, dt_reg};
        end
        rem_next = r2[pid_wc_pkg::TS_W-1:0];
        div_next = {div_reg[pid_wc_pkg::DIV_W-3:0], q1, q2};
    end

    // quotient saturation to the accumulator range
    logic [pid_wc_pkg::DSAT_W-1:0]        q_w, half_w;
    logic signed [pid_wc_pkg::DSAT_W-1:0] dsat;
    logic signed [pid_wc_pkg::ACCUM_WIDTH-1:0] deriv_next;

    assign q_w    = pid_wc_pkg::DSAT_W'(div_reg);
    assign half_w = pid_wc_pkg::DSAT_W'(1) << (pid_wc_pkg::ACCUM_WIDTH - 1);

    always_comb begin
        if (dneg_reg) begin
            dsat = (q_w > half_w) ? -$signed(half_w) : -$signed(q_w);
        end else begin
            dsat = (q_w > half_w - 1'b1) ? $signed(half_w - 1'b1) : $signed(q_w);
        end
        deriv_next = (dt_reg == '0) ? '0 : dsat[pid_wc_pkg::ACCUM_WIDTH-1:0];
    end

    // final sum and output saturation
    logic signed [pid_wc_pkg::TOT_W-1:0] term, total;
    logic [pid_wc_pkg::DRIVE_W-1:0]      drive_next;

    assign term  = pid_wc_pkg::TOT_W'(prod_reg >>> 8);
    assign total = acc_reg + term;

    always_comb begin
        if (total > $signed({{(pid_wc_pkg::TOT_W-pid_wc_pkg::DRIVE_W){1'b0}},
                             1'b0, {(pid_wc_pkg::DRIVE_W-1){1'b1}}})) begin
            drive_next = {1'b0, {(pid_wc_pkg::DRIVE_W-1){1'b1}}};
        end else if (total < $signed({{(pid_wc_pkg::TOT_W-pid_wc_pkg::DRIVE_W){1'b1}},
                                      1'b1, {(pid_wc_pkg::DRIVE_W-1){1'b0}}})) begin
            drive_next = {1'b1, {(pid_wc_pkg::DRIVE_W-1){1'b0}}};
        end else begin
            drive_next = total[pid_wc_pkg::DRIVE_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_acc) state_next = ST_MUL_EDT;
            ST_MUL_EDT: state_next = ST_CLAMP;
            ST_CLAMP:   state_next = ST_DIV;
            ST_DIV:     if (cnt_reg == '0) state_next = ST_DSAT;
            ST_DSAT:    state_next = ST_MUL_P;
            ST_MUL_P:   state_next = ST_MUL_I;
            ST_MUL_I:   state_next = ST_MUL_D;
            ST_MUL_D:   state_next = ST_SUM;
            ST_SUM:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            p_gain_reg  <= pid_wc_pkg::GAIN_W'(256);
            i_gain_reg  <= '0;
            d_gain_reg  <= '0;
            limit_reg   <= '1;
            integ_reg   <= '0;
            prev_reg    <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    pid_wc_pkg::CFG_P_GAIN: p_gain_reg <= cfg_wdata[pid_wc_pkg::GAIN_W-1:0];
                    pid_wc_pkg::CFG_I_GAIN: i_gain_reg <= cfg_wdata[pid_wc_pkg::GAIN_W-1:0];
                    pid_wc_pkg::CFG_D_GAIN: d_gain_reg <= cfg_wdata[pid_wc_pkg::GAIN_W-1:0];
                    pid_wc_pkg::CFG_LIMIT:  limit_reg  <= cfg_wdata[pid_wc_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end

            // ST_SUM loads the register itself when it is free
            if (m_tready && (state_reg != ST_SUM)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        e_reg    <= e_in;
                        dt_reg   <= dt_in;
                        prev_reg <= e_in;
                        dneg_reg <= diff[pid_wc_pkg::ERROR_WIDTH];
                        div_reg  <= pid_wc_pkg::DIV_W'({mag, pid_wc_pkg::TS_W'(0)});
                        rem_reg  <= '0;
                        cnt_reg  <= pid_wc_pkg::DIV_CNT_W'(pid_wc_pkg::DIV_STEPS - 1);
                    end
                end
                ST_MUL_EDT: prod_reg <= prod;
                ST_CLAMP: begin
                    integ_reg   <= sum_clamped[pid_wc_pkg::ACCUM_WIDTH-1:0];
                    clamped_reg <= clamp_hit;
                end
                ST_DIV: begin
                    div_reg <= div_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - 1'b1;
                end
                ST_DSAT:  deriv_reg <= deriv_next;
                ST_MUL_P: prod_reg <= prod;
                ST_MUL_I: begin
                    prod_reg <= prod;
                    acc_reg  <= term;
                end
                ST_MUL_D: begin
                    prod_reg <= prod;
                    acc_reg  <= total;
                end
                ST_SUM: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_drive_reg <= drive_next;
                        m_clamp_reg <= clamped_reg;
                        m_zero_reg  <= (dt_reg == '0);
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = pid_wc_pkg::OUT_TDATA_W'(m_drive_reg);
    assign m_tuser  = {m_zero_reg, m_clamp_reg};

    // no second item may slip in behind an accepted one
    `PWC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_acc, !s_tready, "item accepted while busy")
    // integrator stays inside the bound once clamped
    `PWC_ASSERT_NEXT(a_integ_bounded, aclk, aresetn, state_reg == ST_CLAMP, (integ_ext <= bound_s) && (integ_ext >= -bound_s), "integrator beyond windup bound")
    // zero step forces a zero derivative
    `PWC_ASSERT_NEXT(a_zero_deriv, aclk, aresetn, (state_reg == ST_DSAT) && (dt_reg == '0), deriv_reg == '0, "derivative not zeroed for zero step")
    // a result is only loaded when the output register is free
    `PWC_ASSERT_NOW(a_no_overwrite, aclk, aresetn, (state_reg == ST_SUM) && m_valid_reg && !m_tready, state_next == ST_SUM, "pending result overwritten")

endmodule

[sim/tb_pid_with_windup_clamp.sv]
`timescale 1ns / 100ps

module tb_pid_with_windup_clamp;

    localparam int  CYCLE_LIMIT  = 1_500_000;
    localparam int  SETTLE_CYC   = 30;
    localparam int  RAND_PHASES  = 10;
    localparam int  RAND_PER_PH  = 170;
    localparam longint DRV_MAX   = 64'sd2147483647;
    localparam longint DRV_MIN   = -64'sd2147483648;
    localparam longint QUOT_CAP  = 64'sd2147483648;

    typedef struct {
        logic signed [15:0] err;
        logic [15:0]        dt;
    } sample_t;

    typedef struct {
        logic signed [31:0] drive;
        logic               clamped;
        logic               zero_step;
    } pid_result_t;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               cfg_wr_en = 1'b0;
    logic [pid_wc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [pid_wc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [pid_wc_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [pid_wc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [pid_wc_pkg::OUT_TUSER_W-1:0] m_tuser;

    pid_with_windup_clamp dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state and register copies
    logic [15:0] kp = 16'd256;
    logic [15:0] ki = 16'd0;
    logic [15:0] kd = 16'd0;
    logic [30:0] wlimit = 31'h7fff_ffff;
    longint      integ_st = 0;
    longint      prev_err_st = 0;

    sample_t     samples_q[$];
    pid_result_t expected_outputs[$];
    sample_t     cur_sample;

    bit idle_on = 1'b0;
    int gap_cnt = 0;
    int stall_cnt = 0;
    int cycles = 0;
    int n_errors = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_clamped = 0;
    int n_zero = 0;
    int n_sat = 0;
    int n_settings = 0;

    function automatic pid_result_t pid_step(logic signed [15:0] err, logic [15:0] dt);
        longint e, t, bound, sum, diff, mag, q, deriv;
        longint gp, gi, gd, pterm, iterm, dterm, total;
        pid_result_t r;
        e = longint'(err);
        t = longint'(dt);
        bound = longint'(wlimit);
        gp = longint'(kp);
        gi = longint'(ki);
        gd = longint'(kd);
        r.clamped = 1'b0;
        r.zero_step = 1'b0;

        sum = integ_st + ((e * t) >>> 16);
        if (sum < -bound) begin
            sum = -bound;
            r.clamped = 1'b1;
        end else if (sum > bound) begin
            sum = bound;
            r.clamped = 1'b1;
        end
        integ_st = sum;

        if (t == 0) begin
            deriv = 0;
            r.zero_step = 1'b1;
        end else begin
            diff = e - prev_err_st;
            mag = (diff < 0) ? -diff : diff;
            q = (mag << 16) / t;
            if (q > QUOT_CAP)
                q = QUOT_CAP;
            // negative side may reach -2^31, positive side stops at 2^31-1
            deriv = (diff < 0) ? -q : ((q > DRV_MAX) ? DRV_MAX : q);
        end

        pterm = (gp * e) >>> 8;
        iterm = (gi * integ_st) >>> 8;
        dterm = (gd * deriv) >>> 8;
        total = pterm + iterm + dterm;
        if (total > DRV_MAX)
            total = DRV_MAX;
        else if (total < DRV_MIN)
            total = DRV_MIN;
        r.drive = total[31:0];
        prev_err_st = e;
        return r;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on)
            return 0;
        if (r < 70)
            return $urandom_range(0, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        n_errors++;
    endtask

    // driver: one item in flight on the s_ side, fed from samples_q
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                expected_outputs.push_back(pid_step(cur_sample.err, cur_sample.dt));
                n_accepted++;
                gap_cnt = draw_gap();
            end
            if (gap_cnt > 0) begin
                gap_cnt--;
                s_tvalid <= 1'b0;
            end else if (samples_q.size() > 0) begin
                cur_sample = samples_q.pop_front();
                s_tdata <= {cur_sample.dt, cur_sample.err};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks each result item against the oldest prediction
    always @(posedge aclk) begin
        pid_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                n_clamped += int'(m_tuser[0]);
                n_zero += int'(m_tuser[1]);
                if ($signed(m_tdata) == DRV_MAX || $signed(m_tdata) == DRV_MIN)
                    n_sat++;
                if (expected_outputs.size() == 0) begin
                    report("unexpected item", longint'($signed(m_tdata)), 0);
                end else begin
                    want = expected_outputs.pop_front();
                    if (m_tdata !== want.drive)
                        report("drive_value", longint'($signed(m_tdata)),
                               longint'(want.drive));
                    if (m_tuser[0] !== want.clamped)
                        report("integrator_clamped", longint'(m_tuser[0]),
                               longint'(want.clamped));
                    if (m_tuser[1] !== want.zero_step)
                        report("zero_step", longint'(m_tuser[1]),
                               longint'(want.zero_step));
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    stall_cnt = draw_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items still expected",
                     cycles, expected_outputs.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic cfg_write(pid_wc_pkg::cfg_idx_t idx, logic [30:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            pid_wc_pkg::CFG_P_GAIN: kp = val[15:0];
            pid_wc_pkg::CFG_I_GAIN: ki = val[15:0];
            pid_wc_pkg::CFG_D_GAIN: kd = val[15:0];
            pid_wc_pkg::CFG_LIMIT:  wlimit = val;
            default: ;
        endcase
    endtask

    task automatic set_all(int p, int i, int d, logic [30:0] lim);
        cfg_write(pid_wc_pkg::CFG_P_GAIN, 31'(p));
        cfg_write(pid_wc_pkg::CFG_I_GAIN, 31'(i));
        cfg_write(pid_wc_pkg::CFG_D_GAIN, 31'(d));
        cfg_write(pid_wc_pkg::CFG_LIMIT, lim);
        n_settings++;
    endtask

    // wait for the phase to empty, then let the sequencer come back to idle
    task automatic drain();
        while (samples_q.size() > 0 || s_tvalid || expected_outputs.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    function automatic void add_sample(int err, int dt);
        sample_t s;
        s.err = err[15:0];
        s.dt = dt[15:0];
        samples_q.push_back(s);
    endfunction

    function automatic int pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        if (r < 30)
            return 65535;
        if (r < 50)
            return $urandom_range(0, 512);
        return $urandom_range(0, 65535);
    endfunction

    function automatic logic [30:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 30)
            return 31'h7fff_ffff;
        if (r < 70)
            return 31'($urandom_range(0, 200000));
        return 31'($urandom());
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            s.err = 16'sh7fff;
        else if (r < 10)
            s.err = 16'sh8000;
        else if (r < 40)
            s.err = 16'(int'($urandom_range(0, 1023)) - 512);
        else
            s.err = 16'($urandom());
        r = $urandom_range(0, 99);
        if (r < 10)
            s.dt = 16'd0;
        else if (r < 20)
            s.dt = 16'd1;
        else if (r < 30)
            s.dt = 16'hffff;
        else if (r < 60)
            s.dt = 16'($urandom_range(1, 255));
        else
            s.dt = 16'($urandom());
        return s;
    endfunction

    initial begin
        int ph;
        int k;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset gains: plain proportional path
        add_sample(0, 0);
        add_sample(32767, 65535);
        add_sample(-32768, 65535);
        add_sample(-32768, 0);
        add_sample(1, 1);
        add_sample(-1, 1);
        drain();

        // all gains at full scale, zero bound: derivative and drive saturation
        idle_on = 1'b1;
        set_all(65535, 65535, 65535, 31'd0);
        add_sample(32767, 1);
        add_sample(-32768, 1);
        add_sample(-32768, 0);
        add_sample(32767, 65535);
        add_sample(0, 65535);
        add_sample(-32768, 65535);
        drain();

        // small bound: clamp on both sides, floor on a negative increment
        set_all(0, 256, 0, 31'd1000);
        add_sample(32767, 65535);
        add_sample(0, 1000);
        add_sample(-32768, 65535);
        add_sample(-32768, 65535);
        add_sample(1000, 65535);
        add_sample(12, 3);
        add_sample(-1, 1);
        drain();

        // unit gains: floor on each term
        set_all(1, 1, 1, 31'h7fff_ffff);
        add_sample(-1, 2);
        add_sample(-3, 7);
        add_sample(5, 65535);
        drain();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            idle_on = (ph % 4) != 3;
            set_all(pick_gain(), pick_gain(), pick_gain(), pick_limit());
            for (k = 0; k < RAND_PER_PH; k++)
                samples_q.push_back(random_sample());
            drain();
        end

        $display("%0d items checked over %0d register settings: %0d clamped, %0d zero-step,",
                 n_results, n_settings + 1, n_clamped, n_zero);
        $display("%0d at drive saturation, %0d mismatches", n_sat, n_errors);
        if (n_errors == 0 && expected_outputs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
